// File: sv/qft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_pkg: shared types and constants of the quadrature frequency tuner
// Register indexes, mode and op codes, rotation codes, reset values and the
// control structs that pass between the tuner modules.
// ----------------------------------------------------------------------------
package qft_pkg;

  // Stream word widths
  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 72;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int LIMIT_W = 32;
  localparam int STEP_W = 32;
  localparam int RELAX_W = 16;
  localparam int LPRESS_W = 24;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_TABLE       = 3'd1,
    CFG_LOW_LIMIT   = 3'd2,
    CFG_HIGH_LIMIT  = 3'd3,
    CFG_MIN_STEP    = 3'd4,
    CFG_MAX_STEP    = 3'd5,
    CFG_RELAX       = 3'd6,
    CFG_LONG_PRESS  = 3'd7
  } cfg_index_t;

  // Operating modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_TUNE   = 2'd2;

  // Input ops
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // Transition table codes and output direction codes
  localparam logic [1:0] ROT_PLUS  = 2'd1;
  localparam logic [1:0] ROT_MINUS = 2'd3;
  localparam logic [1:0] DIR_NONE  = 2'b00;
  localparam logic [1:0] DIR_UP    = 2'b01;
  localparam logic [1:0] DIR_DOWN  = 2'b11;

  // Register reset values
  localparam logic [1:0]          RST_MODE       = MODE_OFF;
  localparam logic [31:0]         RST_TABLE      = 32'd28;
  localparam logic [LIMIT_W-1:0]  RST_LOW_LIMIT  = 32'd0;
  localparam logic [LIMIT_W-1:0]  RST_HIGH_LIMIT = 32'hFFFF_FFFF;
  localparam logic [STEP_W-1:0]   RST_MIN_STEP   = 32'd1;
  localparam logic [STEP_W-1:0]   RST_MAX_STEP   = 32'd10_000_000;
  localparam logic [RELAX_W-1:0]  RST_RELAX      = 16'd100;
  localparam logic [LPRESS_W-1:0] RST_LONG_PRESS = 24'd10_000;
  localparam logic [STEP_W-1:0]   RST_STEP       = 32'd1;

  typedef struct packed {
    logic press;
    logic long_press;
  } btn_evt_t;

  typedef struct packed {
    logic load;
    logic tune;
    logic press;
    logic dir_up;
    logic dir_dn;
  } tune_ctl_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] low_limit;
    logic [LIMIT_W-1:0] high_limit;
    logic [STEP_W-1:0]  min_step;
    logic [STEP_W-1:0]  max_step;
  } tune_cfg_t;

endpackage

// File: sv/quadrature_frequency_tuner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_frequency_tuner_unit: rotary encoder frequency tuner
// Decodes encoder A/B steps and knob presses into a clamped frequency and a
// decade step size, with pending flags for a downstream consumer.
// ----------------------------------------------------------------------------
// One word goes in per clock while the output is not held, and one result
// word comes out per input word. Each word passes an input register and a
// result register. The state update for a word (decode, debounce, step and
// frequency add/clamp) happens in the same cycle in which it moves from the
// input register to the result register. Input words are accepted while a
// result waits as long as the input register is empty or can move on.
// Configuration writes are meant for idle periods only.
// ----------------------------------------------------------------------------
module quadrature_frequency_tuner_unit #(
  parameter int FREQ_BITS = 32,
  parameter int HOLD_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [qft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qft_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // enc_ab[1:0], button_level[2], clear_pending[3], load_value[35:4], zero pad
  input  logic [qft_pkg::S_TDATA_W-1:0]   s_tdata,
  // op[0]
  input  logic [qft_pkg::S_TUSER_W-1:0]   s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // direction[1:0], press_event[2], long_press_event[3], skipped[4],
  // frequency[36:5], step_size[68:37], pending[70:69], zero pad
  output logic [qft_pkg::M_TDATA_W-1:0]   m_tdata
);
  import qft_pkg::*;

  // configuration registers
  logic [1:0]          mode;
  logic [31:0]         transition_table;
  tune_cfg_t           tcfg;
  logic [RELAX_W-1:0]  relax_ticks;
  logic [LPRESS_W-1:0] long_press_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= RST_MODE;
      transition_table <= RST_TABLE;
      tcfg.low_limit   <= RST_LOW_LIMIT;
      tcfg.high_limit  <= RST_HIGH_LIMIT;
      tcfg.min_step    <= RST_MIN_STEP;
      tcfg.max_step    <= RST_MAX_STEP;
      relax_ticks      <= RST_RELAX;
      long_press_ticks <= RST_LONG_PRESS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:       mode             <= cfg_data[1:0];
        CFG_TABLE:      transition_table <= cfg_data;
        CFG_LOW_LIMIT:  tcfg.low_limit   <= cfg_data;
        CFG_HIGH_LIMIT: tcfg.high_limit  <= cfg_data;
        CFG_MIN_STEP:   tcfg.min_step    <= cfg_data;
        CFG_MAX_STEP:   tcfg.max_step    <= cfg_data;
        CFG_RELAX:      relax_ticks      <= cfg_data[RELAX_W-1:0];
        CFG_LONG_PRESS: long_press_ticks <= cfg_data[LPRESS_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic        in_valid;
  logic        in_op;
  logic [1:0]  in_ab;
  logic        in_level;
  logic        in_clr;
  logic [31:0] in_load;
  logic        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= s_tuser[0];
      in_ab    <= s_tdata[1:0];
      in_level <= s_tdata[2];
      in_clr   <= s_tdata[3];
      in_load  <= s_tdata[35:4];
    end
  end

  // tick judgement
  logic [1:0] prev_ab;
  logic [1:0] pending_bits, pend_clr, pending_next;
  logic       is_tick, skip, active, tuning;
  logic [1:0] rot_code;
  logic       dir_up, dir_dn;
  logic [1:0] dir_code;

  assign is_tick  = advance && (in_op == OP_TICK);
  assign pend_clr = in_clr ? 2'b00 : pending_bits;
  assign skip     = is_tick && (pend_clr != 2'b00);
  assign active   = is_tick && !skip && (mode == MODE_REPORT || mode == MODE_TUNE);
  assign tuning   = is_tick && !skip && (mode == MODE_TUNE);

  assign rot_code = transition_table[{prev_ab, in_ab, 1'b0} +: 2];
  assign dir_up   = active && (rot_code == ROT_PLUS);
  assign dir_dn   = active && (rot_code == ROT_MINUS);
  assign dir_code = dir_up ? DIR_UP : (dir_dn ? DIR_DOWN : DIR_NONE);

  btn_evt_t btn_evt;

  qft_button #(
    .HOLD_BITS(HOLD_BITS)
  ) u_button (
    .clk              (clk),
    .rst              (rst),
    .en               (active),
    .level            (in_level),
    .relax_ticks      (relax_ticks),
    .long_press_ticks (long_press_ticks),
    .evt              (btn_evt)
  );

  tune_ctl_t        tctl;
  logic             step_changed;
  logic [STEP_W-1:0]  step_next;
  logic [LIMIT_W-1:0] freq_out_next;

  assign tctl.load   = advance && (in_op == OP_LOAD);
  assign tctl.tune   = tuning;
  assign tctl.press  = btn_evt.press;
  assign tctl.dir_up = dir_up;
  assign tctl.dir_dn = dir_dn;

  qft_tune #(
    .FREQ_BITS(FREQ_BITS)
  ) u_tune (
    .clk           (clk),
    .rst           (rst),
    .ctl           (tctl),
    .cfg           (tcfg),
    .load_value    (in_load),
    .step_changed  (step_changed),
    .step_next     (step_next),
    .freq_out_next (freq_out_next)
  );

  always_comb begin
    pending_next = pending_bits;
    if (is_tick) begin
      pending_next = pend_clr;
      if (tuning && step_changed)      pending_next[0] = 1'b1;
      if (tuning && (dir_up || dir_dn)) pending_next[1] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab      <= '0;
      pending_bits <= '0;
    end else begin
      if (active) prev_ab <= in_ab;
      pending_bits <= pending_next;
    end
  end

  // result register
  logic [1:0]         out_dir;
  logic               out_press, out_long, out_skip;
  logic [LIMIT_W-1:0] out_freq;
  logic [STEP_W-1:0]  out_step;
  logic [1:0]         out_pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_dir     <= dir_code;
      out_press   <= btn_evt.press;
      out_long    <= btn_evt.long_press;
      out_skip    <= skip;
      out_freq    <= freq_out_next;
      out_step    <= step_next;
      out_pending <= pending_next;
    end
  end

  assign m_tdata = {1'b0, out_pending, out_step, out_freq, out_skip, out_long,
                    out_press, out_dir};

  // a skipped tick reports no activity
  a_skip_quiet: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_skip |-> out_dir == DIR_NONE && !out_press && !out_long)
    else $error("skipped tick reported activity");

  // a tick is only skipped while an update is still pending
  a_skip_pending: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_skip |-> out_pending != 2'b00)
    else $error("skipped tick with no pending bits");

  // a load leaves the pending bits alone
  a_load_pending: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_LOAD |=> pending_bits == $past(pending_bits))
    else $error("load op changed pending bits");

  // input stalls only when both registers are full and the output is held
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a full pipeline");

endmodule

// File: sv/qft_button.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_button: knob button debounce and long press detect
// Relaxation counter blocks new presses until the button has been released
// long enough; a hold counter fires a long press event past its limit.
// ----------------------------------------------------------------------------
module qft_button #(
  parameter int HOLD_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          level,
  input  logic [qft_pkg::RELAX_W-1:0]   relax_ticks,
  input  logic [qft_pkg::LPRESS_W-1:0]  long_press_ticks,
  output qft_pkg::btn_evt_t             evt
);
  import qft_pkg::*;

  localparam int HW = (HOLD_BITS > LPRESS_W) ? HOLD_BITS : LPRESS_W;

  logic [RELAX_W-1:0]   relax_count, relax_count_next;
  logic [HOLD_BITS-1:0] hold_count, hold_count_next;
  logic [HW-1:0]        hold_ext, lpt_ext;

  assign hold_ext = HW'(hold_count);
  assign lpt_ext  = HW'(long_press_ticks);

  always_comb begin
    relax_count_next = relax_count;
    hold_count_next  = hold_count;
    evt              = '0;
    if (en) begin
      if (!level && relax_count == '0) begin
        // qualified press: hold counter stays put this tick
        relax_count_next = relax_ticks;
        evt.press        = 1'b1;
      end else if (level) begin
        if (relax_count != '0) begin
          relax_count_next = relax_count - RELAX_W'(1);
        end
        hold_count_next = '0;
      end else begin
        if (hold_count != '1) begin
          hold_count_next = hold_count + HOLD_BITS'(1);
        end
        if (hold_ext > lpt_ext) begin
          evt.long_press  = 1'b1;
          hold_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relax_count <= '0;
      hold_count  <= '0;
    end else begin
      relax_count <= relax_count_next;
      hold_count  <= hold_count_next;
    end
  end

endmodule

// File: sv/qft_tune.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_tune: step and frequency update
// Multiplies the step by ten on a press (wrapping to the minimum), steps the
// frequency up or down with clamping to the limits, and loads a new value.
// ----------------------------------------------------------------------------
module qft_tune #(
  parameter int FREQ_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  qft_pkg::tune_ctl_t           ctl,
  input  qft_pkg::tune_cfg_t           cfg,
  input  logic [qft_pkg::LIMIT_W-1:0]  load_value,
  output logic                         step_changed,
  output logic [qft_pkg::STEP_W-1:0]   step_next,
  output logic [qft_pkg::LIMIT_W-1:0]  freq_out_next
);
  import qft_pkg::*;

  // sum width: one carry bit above the wider of frequency and limits
  localparam int SW = ((FREQ_BITS > LIMIT_W) ? FREQ_BITS : LIMIT_W) + 1;

  logic [STEP_W-1:0]    step_reg;
  logic [FREQ_BITS-1:0] freq_reg, freq_next;
  logic [STEP_W+3:0]    step_x10;
  logic [SW-1:0]        f_ext, s_ext, lo_ext, hi_ext, sum, rot, clamped, nx_ext;

  assign step_x10 = ({4'b0, step_reg} << 3) + ({4'b0, step_reg} << 1);

  always_comb begin
    step_next = step_reg;
    if (ctl.tune && ctl.press) begin
      if (step_x10 > {4'b0, cfg.max_step}) begin
        step_next = cfg.min_step;
      end else begin
        step_next = step_x10[STEP_W-1:0];
      end
    end
  end

  assign step_changed = (step_next != step_reg);

  assign f_ext  = SW'(freq_reg);
  assign s_ext  = SW'(step_next);
  assign lo_ext = SW'(cfg.low_limit);
  assign hi_ext = SW'(cfg.high_limit);
  assign sum    = f_ext + s_ext;

  always_comb begin
    if (ctl.dir_up) begin
      // anything past the frequency width goes to the high limit
      if ((sum >> FREQ_BITS) != '0) rot = hi_ext;
      else                          rot = sum;
    end else begin
      if (s_ext > f_ext) rot = lo_ext;
      else               rot = f_ext - s_ext;
    end
    clamped = rot;
    if (clamped < lo_ext) clamped = lo_ext;
    if (clamped > hi_ext) clamped = hi_ext;
  end

  always_comb begin
    freq_next = freq_reg;
    if (ctl.load) begin
      freq_next = FREQ_BITS'(SW'(load_value));
    end else if (ctl.tune && (ctl.dir_up || ctl.dir_dn)) begin
      freq_next = clamped[FREQ_BITS-1:0];
    end
  end

  assign nx_ext        = SW'(freq_next);
  assign freq_out_next = nx_ext[LIMIT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_reg <= RST_STEP;
      freq_reg <= '0;
    end else begin
      step_reg <= step_next;
      freq_reg <= freq_next;
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for quadrature_frequency_tuner_unit
// Streams encoder ticks and frequency loads through the tuner with random
// gaps and stalls on both sides. A cycle-free model of the tuner predicts each
// result word, which the monitor compares field by field. Configuration is
// rewritten between phases while the tuner is idle.
// ----------------------------------------------------------------------------
module testbench;
  import qft_pkg::*;

  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  // Full quadrature table: 0-1-3-2 counts up, the reverse counts down, and
  // staying at 00 or 11 gives code 2 (no rotation)
  localparam logic [31:0] QUAD_TABLE  = 32'h9CC1_4336;

  // enc_ab is the lowest field
  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] load_value;
    logic        clear_pending;
    logic        button_level;
    logic [1:0]  enc_ab;
  } input_word_t;

  // direction is the lowest field
  typedef struct packed {
    logic        pad;
    logic [1:0]  pending;
    logic [31:0] step_size;
    logic [31:0] frequency;
    logic        skipped;
    logic        long_press_event;
    logic        press_event;
    logic [1:0]  direction;
  } result_word_t;

  typedef struct packed {
    logic        op;
    input_word_t word;
  } tuner_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  cfg_index_t cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [S_TUSER_W-1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  // Register copies as last written
  logic [1:0]          reg_mode       = RST_MODE;
  logic [31:0]         reg_table      = RST_TABLE;
  logic [LIMIT_W-1:0]  reg_low        = RST_LOW_LIMIT;
  logic [LIMIT_W-1:0]  reg_high       = RST_HIGH_LIMIT;
  logic [STEP_W-1:0]   reg_min_step   = RST_MIN_STEP;
  logic [STEP_W-1:0]   reg_max_step   = RST_MAX_STEP;
  logic [RELAX_W-1:0]  reg_relax      = RST_RELAX;
  logic [LPRESS_W-1:0] reg_long_press = RST_LONG_PRESS;

  // Tuner state as predicted
  logic [1:0]          knob_prev_ab = '0;
  logic [RELAX_W-1:0]  relax_left   = '0;
  logic [LPRESS_W-1:0] hold_ticks   = '0;
  logic [STEP_W-1:0]   step_now     = RST_STEP;
  logic [31:0]         freq_now     = '0;
  logic [1:0]          pending_now  = '0;

  tuner_item_t  send_words[$];
  result_word_t tuner_expect[$];
  int  words_queued = 0;
  int  words_accepted = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;
  int  tx_wait = 0;
  int  rx_wait = 0;
  logic tx_gaps_on = 1'b1;
  logic rx_gaps_on = 1'b1;
  logic rx_hold = 1'b0;
  event hold_request;

  // Random walk of the encoder and the button
  logic [1:0] walk_ab = 2'b00;
  logic       walk_up = 1'b1;
  logic       btn_level = 1'b1;
  int         btn_run = 0;

  quadrature_frequency_tuner_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_word_t advance_tuner(input logic op, input input_word_t w);
    result_word_t r;
    logic [1:0] code;
    logic [LPRESS_W-1:0] held;
    logic [63:0] wide;
    logic [STEP_W-1:0] prior_step;
    r = '0;
    if (op == OP_LOAD) begin
      freq_now = w.load_value;
    end else begin
      if (w.clear_pending) pending_now = 2'b00;
      if (pending_now != 2'b00) begin
        r.skipped = 1'b1;
      end else if (reg_mode == MODE_REPORT || reg_mode == MODE_TUNE) begin
        prior_step = step_now;
        code = 2'(reg_table >> {knob_prev_ab, w.enc_ab, 1'b0});
        knob_prev_ab = w.enc_ab;
        if (code == ROT_PLUS) r.direction = DIR_UP;
        else if (code == ROT_MINUS) r.direction = DIR_DOWN;

        if (!w.button_level && relax_left == '0) begin
          relax_left = reg_relax;
          r.press_event = 1'b1;
        end else if (w.button_level) begin
          if (relax_left != '0) relax_left = relax_left - RELAX_W'(1);
          hold_ticks = '0;
        end else begin
          // saturate the hold count, fire on the old value
          held = hold_ticks;
          if (hold_ticks != '1) hold_ticks = hold_ticks + LPRESS_W'(1);
          if (held > reg_long_press) begin
            r.long_press_event = 1'b1;
            hold_ticks = '0;
          end
        end

        if (reg_mode == MODE_TUNE) begin
          if (r.press_event) begin
            wide = 64'(step_now) * 64'd10;
            if (wide > 64'(reg_max_step)) wide = 64'(reg_min_step);
            step_now = wide[31:0];
          end
          if (step_now != prior_step) pending_now[0] = 1'b1;
          if (r.direction != DIR_NONE) begin
            if (r.direction == DIR_UP) begin
              wide = 64'(freq_now) + 64'(step_now);
              if (wide > 64'hFFFF_FFFF) wide = 64'(reg_high);
            end else if (step_now > freq_now) begin
              wide = 64'(reg_low);
            end else begin
              wide = 64'(freq_now - step_now);
            end
            if (wide < 64'(reg_low)) wide = 64'(reg_low);
            if (wide > 64'(reg_high)) wide = 64'(reg_high);
            freq_now = wide[31:0];
            pending_now[1] = 1'b1;
          end
        end
      end
    end
    r.frequency = freq_now;
    r.step_size = step_now;
    r.pending   = pending_now;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("word %0d %s got %0h want %0h", results_seen, name, got, want));
  endtask

  task automatic queue_tick(input logic [1:0] ab, input logic level, input logic clr);
    tuner_item_t it;
    it = '0;
    it.op = OP_TICK;
    it.word.load_value = $urandom;
    it.word.clear_pending = clr;
    it.word.button_level = level;
    it.word.enc_ab = ab;
    send_words.push_back(it);
    words_queued++;
  endtask

  task automatic queue_load(input logic [31:0] value);
    tuner_item_t it;
    it = '0;
    it.op = OP_LOAD;
    it.word.load_value = value;
    it.word.clear_pending = 1'($urandom_range(0, 1));
    it.word.button_level = 1'($urandom_range(0, 1));
    it.word.enc_ab = 2'($urandom_range(0, 3));
    send_words.push_back(it);
    words_queued++;
  endtask

  task automatic queue_random_item();
    int unsigned roll;
    logic [31:0] value;
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      roll = $urandom_range(0, 19);
      if (roll < 10) value = $urandom_range(reg_low, reg_high);
      else if (roll < 13) value = 32'h0;
      else if (roll < 16) value = 32'hFFFF_FFFF;
      else value = $urandom;
      queue_load(value);
    end else begin
      if (btn_run == 0) begin
        btn_level = !btn_level;
        btn_run = btn_level ? $urandom_range(1, 10) : $urandom_range(1, 14);
      end
      btn_run--;
      roll = $urandom_range(0, 99);
      if (roll < 8) walk_up = !walk_up;
      // step one Gray position, stay put, or jump anywhere
      if (roll < 70) walk_ab = walk_up ? {walk_ab[0], ~walk_ab[1]} : {~walk_ab[0], walk_ab[1]};
      else if (roll >= 85) walk_ab = 2'($urandom_range(0, 3));
      queue_tick(walk_ab, btn_level, $urandom_range(0, 99) < 65);
    end
  endtask

  task automatic wait_idle();
    while (words_accepted != words_queued || tuner_expect.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_reg(input cfg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_MODE:       reg_mode = value[1:0];
      CFG_TABLE:      reg_table = value;
      CFG_LOW_LIMIT:  reg_low = value;
      CFG_HIGH_LIMIT: reg_high = value;
      CFG_MIN_STEP:   reg_min_step = value;
      CFG_MAX_STEP:   reg_max_step = value;
      CFG_RELAX:      reg_relax = value[RELAX_W-1:0];
      CFG_LONG_PRESS: reg_long_press = value[LPRESS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Sender: hold each word until taken, then idle for its drawn gap
  always @(negedge clk) begin : sender
    tuner_item_t word_out;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (tx_wait != 0) begin
        s_tvalid <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (send_words.size() != 0) begin
        word_out = send_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= word_out.word;
        s_tuser <= word_out.op;
        tx_wait <= tx_gaps_on ? $urandom_range(0, 5) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall for a drawn count after each word, or while held off
  always @(negedge clk) begin : receiver
    int unsigned pause;
    pause = rx_gaps_on ? $urandom_range(0, 5) : 0;
    if (rst || rx_hold) begin
      m_tready <= 1'b0;
    end else if (rx_wait != 0) begin
      m_tready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else if (out_taken && pause != 0) begin
      m_tready <= 1'b0;
      rx_wait <= pause - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    result_word_t got;
    result_word_t want;
    if (rst) begin
      in_taken <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken <= s_tvalid && s_tready;
      out_taken <= m_tvalid && m_tready;
      if (s_tvalid && s_tready) begin
        tuner_expect.push_back(advance_tuner(s_tuser[0], input_word_t'(s_tdata)));
        words_accepted <= words_accepted + 1;
      end
      if (m_tvalid && m_tready) begin
        got = result_word_t'(m_tdata);
        if (tuner_expect.size() == 0) begin
          report_mismatch($sformatf("word %0d arrived with none outstanding", results_seen));
        end else begin
          want = tuner_expect.pop_front();
          check_field("direction", 32'(got.direction), 32'(want.direction));
          check_field("press_event", 32'(got.press_event), 32'(want.press_event));
          check_field("long_press_event", 32'(got.long_press_event),
                      32'(want.long_press_event));
          check_field("skipped", 32'(got.skipped), 32'(want.skipped));
          check_field("frequency", got.frequency, want.frequency);
          check_field("step_size", got.step_size, want.step_size);
          check_field("pending", 32'(got.pending), 32'(want.pending));
        end
        results_seen++;
      end
    end
  end

  // Long receiver hold-off so the tuner backs up into its input
  initial begin : receiver_hold
    @(hold_request);
    @(negedge clk);
    rx_hold <= 1'b1;
    repeat (48) @(negedge clk);
    rx_hold <= 1'b0;
  end

  initial begin : watchdog
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int unsigned roll;
    logic [31:0] low_pick;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings, inactive: loads at both extremes, ignored tick
    queue_load(32'hFFFF_FFFF);
    queue_tick(2'b01, 1'b0, 1'b0);
    queue_load(32'h0);
    wait_idle();
    set_reg(CFG_MODE, 32'(MODE_UNUSED));
    finish_writes();
    queue_tick(2'b10, 1'b0, 1'b1);

    // Report only: decode and press, no tuning
    wait_idle();
    set_reg(CFG_MODE, 32'(MODE_REPORT));
    finish_writes();
    queue_tick(2'b00, 1'b1, 1'b0);
    queue_tick(2'b01, 1'b0, 1'b0);
    queue_tick(2'b00, 1'b0, 1'b0);
    wait_idle();
    set_reg(CFG_TABLE, 32'hAAAA_AAAA);
    finish_writes();
    queue_tick(2'b11, 1'b1, 1'b0);

    // Tuning: underflow, skip, press, long press, step up
    wait_idle();
    set_reg(CFG_MODE, 32'(MODE_TUNE));
    set_reg(CFG_TABLE, QUAD_TABLE);
    set_reg(CFG_LOW_LIMIT, 32'd100);
    set_reg(CFG_HIGH_LIMIT, 32'd1000);
    set_reg(CFG_MIN_STEP, 32'd1);
    set_reg(CFG_MAX_STEP, 32'd1000);
    set_reg(CFG_RELAX, 32'd2);
    set_reg(CFG_LONG_PRESS, 32'd1);
    finish_writes();
    queue_load(32'd0);
    queue_tick(2'b01, 1'b1, 1'b1);
    queue_tick(2'b01, 1'b1, 1'b0);
    queue_tick(2'b00, 1'b0, 1'b1);
    queue_tick(2'b00, 1'b0, 1'b1);
    queue_tick(2'b00, 1'b0, 1'b1);
    queue_tick(2'b00, 1'b0, 1'b1);
    queue_tick(2'b01, 1'b1, 1'b1);

    // Crossed limits, step wrap at full precision, zero step
    wait_idle();
    set_reg(CFG_LOW_LIMIT, 32'h10);
    set_reg(CFG_HIGH_LIMIT, 32'h8);
    set_reg(CFG_MIN_STEP, 32'd1_000_000_000);
    set_reg(CFG_MAX_STEP, 32'd1);
    set_reg(CFG_RELAX, 32'd1);
    finish_writes();
    queue_load(32'hFFFF_FFF0);
    queue_tick(2'b01, 1'b1, 1'b1);
    queue_tick(2'b01, 1'b0, 1'b1);
    wait_idle();
    set_reg(CFG_MIN_STEP, 32'd0);
    set_reg(CFG_MAX_STEP, 32'hFFFF_FFFF);
    finish_writes();
    queue_tick(2'b11, 1'b0, 1'b1);
    queue_tick(2'b11, 1'b1, 1'b1);
    queue_tick(2'b11, 1'b0, 1'b1);
    queue_tick(2'b10, 1'b1, 1'b1);

    for (int p = 0; p < 7; p++) begin
      wait_idle();
      case (p)
        0: begin
          set_reg(CFG_MODE, 32'(MODE_TUNE));
          set_reg(CFG_TABLE, QUAD_TABLE);
          set_reg(CFG_LOW_LIMIT, 32'h0);
          set_reg(CFG_HIGH_LIMIT, 32'h0);
          set_reg(CFG_MIN_STEP, 32'h0);
          set_reg(CFG_MAX_STEP, 32'h1);
          set_reg(CFG_RELAX, 32'h0);
          set_reg(CFG_LONG_PRESS, 32'h0);
        end
        1: begin
          set_reg(CFG_TABLE, 32'hFFFF_FFFF);
          set_reg(CFG_LOW_LIMIT, 32'hFFFF_FFFF);
          set_reg(CFG_HIGH_LIMIT, 32'hFFFF_FFFF);
          set_reg(CFG_MIN_STEP, 32'hFFFF_FFFF);
          set_reg(CFG_MAX_STEP, 32'hFFFF_FFFF);
          set_reg(CFG_RELAX, 32'hFFFF);
          set_reg(CFG_LONG_PRESS, 32'hFF_FFFF);
        end
        default: begin
          roll = $urandom_range(0, 9);
          if (roll == 0) set_reg(CFG_MODE, 32'(MODE_OFF));
          else if (roll == 1) set_reg(CFG_MODE, 32'(MODE_UNUSED));
          else if (roll < 4) set_reg(CFG_MODE, 32'(MODE_REPORT));
          else set_reg(CFG_MODE, 32'(MODE_TUNE));
          roll = $urandom_range(0, 9);
          if (roll < 5) set_reg(CFG_TABLE, QUAD_TABLE);
          else if (roll < 7) set_reg(CFG_TABLE, RST_TABLE);
          else set_reg(CFG_TABLE, $urandom);
          low_pick = $urandom_range(0, 5000);
          set_reg(CFG_LOW_LIMIT, low_pick);
          roll = $urandom_range(0, 9);
          if (roll == 0) set_reg(CFG_HIGH_LIMIT, $urandom_range(0, low_pick));
          else if (roll == 1) set_reg(CFG_HIGH_LIMIT, 32'hFFFF_FFFF);
          else set_reg(CFG_HIGH_LIMIT, low_pick + $urandom_range(0, 200000));
          roll = $urandom_range(0, 9);
          if (roll == 0) set_reg(CFG_MIN_STEP, 32'h0);
          else if (roll < 6) set_reg(CFG_MIN_STEP, 32'h1);
          else set_reg(CFG_MIN_STEP, $urandom_range(1, 50));
          roll = $urandom_range(0, 3);
          if (roll < 2) set_reg(CFG_MAX_STEP, $urandom_range(1, 100000));
          else if (roll == 2) set_reg(CFG_MAX_STEP, 32'hFFFF_FFFF);
          else set_reg(CFG_MAX_STEP, $urandom);
          if ($urandom_range(0, 4) != 0) set_reg(CFG_RELAX, $urandom_range(0, 3));
          else set_reg(CFG_RELAX, $urandom_range(4, 40));
          set_reg(CFG_LONG_PRESS, $urandom_range(0, 12));
        end
      endcase
      finish_writes();
      tx_gaps_on = (p % 3) != 1;
      rx_gaps_on = (p % 2) == 0;
      if (p == 4) -> hold_request;
      repeat (100) queue_random_item();
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/qft_pkg.sv
sv/qft_button.sv
sv/qft_tune.sv
sv/quadrature_frequency_tuner_unit.sv
tb/testbench.sv
